// ===== rtl/sfp_pkg.sv =====
`default_nettype none
package sfp_pkg;

  localparam int WS_DEPTH = 8;
  localparam int WS_IDX_W = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
  localparam int WS_CNT_W = $clog2(WS_DEPTH + 1);
  localparam int NUM_CMDS = 12;

  localparam logic [2:0] ST_CMD  = 3'd0;
  localparam logic [2:0] ST_KEY  = 3'd1;
  localparam logic [2:0] ST_VAL  = 3'd2;
  localparam logic [2:0] ST_PAY  = 3'd3;
  localparam logic [2:0] ST_DROP = 3'd4;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_KEY  = 2'd1;
  localparam logic [1:0] KIND_VAL  = 2'd2;
  localparam logic [1:0] KIND_PAY  = 2'd3;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_CMD_FMT = 3'd1;
  localparam logic [2:0] ERR_UNKNOWN = 3'd2;
  localparam logic [2:0] ERR_HEADER  = 3'd3;
  localparam logic [2:0] ERR_WS_OVF  = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] field_kind;
    logic       field_end;
    logic       command_done;
    logic [3:0] command_code;
    logic [2:0] error_code;
    logic       frame_done;
    logic       last;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
           c == 8'h0C || c == 8'h0D;
  endfunction

  function automatic logic [3:0] cmd_len(input logic [3:0] i);
    case (i)
      4'd0: return 4'd7;
      4'd1: return 4'd9;
      4'd2: return 4'd10;
      4'd3: return 4'd4;
      4'd4: return 4'd9;
      4'd5: return 4'd11;
      4'd6: return 4'd5;
      4'd7: return 4'd6;
      4'd8: return 4'd5;
      4'd9: return 4'd3;
      4'd10: return 4'd4;
      4'd11: return 4'd5;
      default: return 4'd0;
    endcase
  endfunction

  // Character of command word i at position p (NUL past the end).
  function automatic logic [7:0] cmd_char(input logic [3:0] i, input logic [3:0] p);
    logic [87:0] w;
    case (i)
      4'd0: w = {"CONNECT", 32'h0};
      4'd1: w = {"CONNECTED", 16'h0};
      4'd2: w = {"DISCONNECT", 8'h0};
      4'd3: w = {"SEND", 56'h0};
      4'd4: w = {"SUBSCRIBE", 16'h0};
      4'd5: w = "UNSUBSCRIBE";
      4'd6: w = {"BEGIN", 48'h0};
      4'd7: w = {"COMMIT", 40'h0};
      4'd8: w = {"ABORT", 48'h0};
      4'd9: w = {"ACK", 64'h0};
      4'd10: w = {"NACK", 56'h0};
      4'd11: w = {"ERROR", 48'h0};
      default: w = '0;
    endcase
    if (p > 4'd10) return 8'h00;
    return w[8'd87 - {p, 3'b000} -: 8];
  endfunction

  typedef struct packed {
    logic [7:0] c;
    logic       fend;
  } dp_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/sfp_stream_if.sv =====
`default_nettype none
interface sfp_stream_if #(parameter type payload_t = logic [8:0]);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/stomp_frame_parser_top.sv =====
`default_nettype none
// STOMP frame parser.
// The in channel carries one frame byte per transfer with frame_end on the
// last byte. The out channel carries result records: key, value and
// payload bytes with kind tags, field end marks, the command verdict with
// its code, the sticky error code, frame_done and last per input byte.
// Each accepted byte yields zero, one or two results plus any held
// trailing whitespace that a following non-whitespace byte releases.
// A byte that owes a single output cycle lets the next byte transfer in
// the same cycle as its result, so while the receiver is ready such
// bytes sustain one byte per cycle. A byte that owes more output cycles
// (N released whitespace bytes plus its own results) holds off the next
// byte until after its last result has transferred. The first result of
// a byte appears in the cycle after the byte transfers, from the result
// register in the datapath.
// Reset (synchronous, rst high) returns the parser to the command stage
// and empties the result queue. When the receiver stalls, the current
// result holds on the out channel and no new byte is accepted.
// Errors drop the rest of the frame; the frame still closes on frame_end.
module stomp_frame_parser_top (
  input wire logic clk,
  input wire logic rst,
  sfp_stream_if.sink   in_ch,
  sfp_stream_if.source out_ch
);
  import sfp_pkg::*;

  logic take, busy;

  sfp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .take(take), .flush_more(busy)
  );

  sfp_datapath u_dp (
    .clk(clk), .rst(rst), .take(take),
    .data_byte(in_ch.data[8:1]), .frame_end(in_ch.data[0]),
    .busy(busy), .res(out_ch)
  );
endmodule
`default_nettype wire

// ===== rtl/sfp_ctrl.sv =====
`default_nettype none
// Controller: sequences one accepted byte, then walks out its results
// (held whitespace first, then the byte's own results) one per cycle when not stalled.
module sfp_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      take,
  input  wire logic flush_more
);
  import sfp_pkg::*;

  localparam logic [0:0] S_IDLE  = 1'b0;
  localparam logic [0:0] S_FLUSH = 1'b1;

  logic [0:0] state, state_next;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    take       = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !flush_more;
        take     = in_valid && !flush_more;
        if (flush_more) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!flush_more) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/sfp_datapath.sv =====
`default_nettype none
// Datapath: parse state, whitespace buffer and the output queue. Each
// byte produces at most two results besides the held whitespace: those
// go to a two-entry result queue, and held bytes drain ahead of them.
module sfp_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           take,
  input  wire logic [7:0]     data_byte,
  input  wire logic           frame_end,
  output logic                busy,
  sfp_stream_if.source        res
);
  import sfp_pkg::*;

  logic [2:0]             stage;
  logic [NUM_CMDS-1:0]    cmask;
  logic [3:0]             cidx;
  logic                   f_any, f_started;
  logic [7:0]             ws_mem [WS_DEPTH];
  logic [WS_CNT_W-1:0]    pcount;
  logic [2:0]             serr;

  // Output sequence: drain count of held bytes, then up to two queued results.
  logic [WS_CNT_W-1:0]    drain_n, drain_i;
  logic [1:0]             kind_q;
  result_t                q0, q1;
  logic [1:0]             qn;
  logic                   q_any;

  // Combinational evaluation of one byte.
  logic [2:0]          stage_n, err_n;
  logic [NUM_CMDS-1:0] cmask_n;
  logic [3:0]          cidx_n;
  logic                any_n, st_n, wr_ws;
  logic [WS_CNT_W-1:0] pc_n, dn_n;
  result_t             r0, r1;
  logic [1:0]          rn;
  logic [1:0]          fkind;
  logic                hit;
  logic [3:0]          hit_i;
  logic                ecl;

  function automatic result_t mk(input logic [7:0] b, input logic v, input logic [1:0] k,
                                 input logic fe, input logic cd, input logic [3:0] cc,
                                 input logic [2:0] e);
    result_t r;
    r = '0;
    r.out_byte = b; r.byte_valid = v; r.field_kind = k; r.field_end = fe;
    r.command_done = cd; r.command_code = cc; r.error_code = e;
    return r;
  endfunction

  always_comb begin
    logic c_ws;
    logic [2:0] st;
    c_ws = is_ws(data_byte);
    stage_n = stage; cmask_n = cmask; cidx_n = cidx; any_n = f_any; st_n = f_started;
    pc_n = pcount; err_n = serr; wr_ws = 1'b0; dn_n = '0;
    r0 = '0; r1 = '0; rn = 2'd0; fkind = KIND_NONE; hit = 1'b0; hit_i = '0; ecl = 1'b0;
    case (stage)
      ST_CMD: begin
        if (data_byte == CH_NUL || data_byte == CH_SPACE) begin
          err_n = ERR_CMD_FMT; stage_n = ST_DROP; pc_n = '0;
          r0 = mk(8'h0, 1'b0, KIND_NONE, 1'b0, 1'b1, 4'd0, err_n); rn = 2'd1;
        end else if (data_byte == CH_LF) begin
          ecl = 1'b1;
        end else if (c_ws) begin
          if (f_any) st_n = 1'b1;
        end else begin
          if (f_started) cmask_n = '0;
          for (int i = 0; i < NUM_CMDS; i++) begin
            if (cidx >= cmd_len(4'(i)) || cmd_char(4'(i), cidx) != data_byte)
              cmask_n[i] = 1'b0;
          end
          if (cidx < 4'd15) cidx_n = cidx + 4'd1;
          any_n = 1'b1;
        end
      end
      ST_KEY, ST_VAL: begin
        fkind = (stage == ST_KEY) ? KIND_KEY : KIND_VAL;
        if (data_byte == CH_NUL) begin
          err_n = ERR_HEADER; stage_n = ST_DROP; pc_n = '0;
          r0 = mk(8'h0, 1'b0, KIND_NONE, 1'b0, 1'b0, 4'd0, err_n); rn = 2'd1;
        end else if (data_byte == CH_LF) begin
          ecl = 1'b1;
        end else if (stage == ST_KEY && data_byte == CH_COLON) begin
          pc_n = '0; stage_n = ST_VAL; any_n = 1'b0; st_n = 1'b0;
          r0 = mk(8'h0, 1'b0, KIND_KEY, 1'b1, 1'b0, 4'd0, serr); rn = 2'd1;
        end else begin
          any_n = 1'b1;
          if (c_ws) begin
            if (f_started) begin
              if (pcount >= WS_CNT_W'(WS_DEPTH)) begin
                err_n = ERR_WS_OVF; stage_n = ST_DROP; pc_n = '0;
                r0 = mk(8'h0, 1'b0, KIND_NONE, 1'b0, 1'b0, 4'd0, err_n); rn = 2'd1;
              end else begin
                wr_ws = 1'b1; pc_n = pcount + 1'b1;
              end
            end
          end else begin
            dn_n = pcount; pc_n = '0; st_n = 1'b1;
            r0 = mk(data_byte, 1'b1, fkind, 1'b0, 1'b0, 4'd0, serr); rn = 2'd1;
          end
        end
      end
      ST_PAY: begin
        r0 = mk(data_byte, 1'b1, KIND_PAY, 1'b0, 1'b0, 4'd0, serr); rn = 2'd1;
      end
      default: stage_n = ST_DROP;
    endcase

    // Frame end closes an open command or header line like a line feed.
    st = stage_n;
    if (frame_end && (st == ST_CMD || st == ST_VAL || (st == ST_KEY && any_n)))
      ecl = 1'b1;

    if (ecl) begin
      if (st == ST_CMD) begin
        for (int i = NUM_CMDS - 1; i >= 0; i--) begin
          if (cmask_n[i] && cmd_len(4'(i)) == cidx_n) begin
            hit = 1'b1; hit_i = 4'(i);
          end
        end
        if (hit) begin
          stage_n = ST_KEY; any_n = 1'b0; st_n = 1'b0; pc_n = '0;
          r1 = mk(8'h0, 1'b0, KIND_NONE, 1'b0, 1'b1, hit_i, err_n);
        end else begin
          err_n = ERR_UNKNOWN; stage_n = ST_DROP; pc_n = '0;
          r1 = mk(8'h0, 1'b0, KIND_NONE, 1'b0, 1'b1, 4'd0, err_n);
        end
      end else if (st == ST_KEY) begin
        if (any_n) begin
          err_n = ERR_HEADER; stage_n = ST_DROP; pc_n = '0;
          r1 = mk(8'h0, 1'b0, KIND_NONE, 1'b0, 1'b0, 4'd0, err_n);
        end else begin
          stage_n = ST_PAY;
        end
      end else if (st == ST_VAL) begin
        if (!any_n) begin
          err_n = ERR_HEADER; stage_n = ST_DROP; pc_n = '0;
          r1 = mk(8'h0, 1'b0, KIND_NONE, 1'b0, 1'b0, 4'd0, err_n);
        end else begin
          pc_n = '0; stage_n = ST_KEY; any_n = 1'b0; st_n = 1'b0;
          r1 = mk(8'h0, 1'b0, KIND_VAL, 1'b1, 1'b0, 4'd0, err_n);
        end
      end
      if (r1.command_done || r1.field_end || r1.error_code != err_n ||
          (st != ST_PAY && stage_n == ST_DROP) || (st == ST_VAL)) begin
        if (!(st == ST_KEY && !any_n)) begin
          if (rn == 2'd0) begin r0 = r1; rn = 2'd1; end
          else begin rn = 2'd2; end
        end
      end
    end

    if (frame_end) begin
      if (rn == 2'd0 && dn_n == '0) begin
        r0 = mk(8'h0, 1'b0, KIND_NONE, 1'b0, 1'b0, 4'd0, err_n); rn = 2'd1;
      end
      if (rn == 2'd2) begin r1.error_code = err_n; r1.frame_done = 1'b1; end
      else begin r0.error_code = err_n; r0.frame_done = 1'b1; end
    end
    if (rn == 2'd2) r1.last = 1'b1;
    else r0.last = 1'b1;
  end

  assign q_any = (drain_i != drain_n) || (qn != 2'd0);
  assign busy  = q_any && !(res.ready && drain_i == drain_n && qn == 2'd1);

  always_comb begin
    res.valid = q_any;
    if (drain_i != drain_n) begin
      res.data = mk(ws_mem[drain_i[WS_IDX_W-1:0]], 1'b1, kind_q, 1'b0, 1'b0, 4'd0, q0.error_code);
    end else begin
      res.data = q0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ws && take) ws_mem[pcount[WS_IDX_W-1:0]] <= data_byte;
    if (rst) begin
      stage <= ST_CMD; cmask <= '1; cidx <= '0; f_any <= 1'b0; f_started <= 1'b0;
      pcount <= '0; serr <= ERR_NONE; drain_n <= '0; drain_i <= '0; qn <= 2'd0;
      kind_q <= KIND_NONE;
    end else begin
      // A byte is taken only when the queue is empty or its last entry is
      // leaving, so loading the queue replaces the pop.
      if (take) begin
        drain_i <= '0; drain_n <= dn_n; kind_q <= fkind; q0 <= r0; q1 <= r1; qn <= rn;
        if (frame_end) begin
          stage <= ST_CMD; cmask <= '1; cidx <= '0; f_any <= 1'b0; f_started <= 1'b0;
          pcount <= '0; serr <= ERR_NONE;
        end else begin
          stage <= stage_n; cmask <= cmask_n; cidx <= cidx_n; f_any <= any_n;
          f_started <= st_n; pcount <= pc_n; serr <= err_n;
        end
      end else if (res.valid && res.ready) begin
        if (drain_i != drain_n) drain_i <= drain_i + 1'b1;
        else begin q0 <= q1; qn <= qn - 2'd1; end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/sfp_checker.sv =====
`default_nettype none
module sfp_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire sfp_pkg::result_t out_data
);
  import sfp_pkg::*;
  result_t r;
  assign r = out_data;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_stall_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("byte accepted while result stalled");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && r.frame_done |-> r.last)
    else $error("frame_done without last");
  a_err_nobyte: assert property (@(posedge clk) disable iff (rst)
    out_valid && r.command_done && r.error_code != ERR_NONE |-> !r.byte_valid)
    else $error("error result carries byte");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");
endmodule

bind stomp_frame_parser_top sfp_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import sfp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Byte channel into the parser and result channel out of it.
  sfp_stream_if #(.payload_t(dp_cmd_t)) in_if ();
  sfp_stream_if #(.payload_t(result_t)) out_if ();

  stomp_frame_parser_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The twelve command words, in code order.
  string cmd_word [NUM_CMDS] = '{"CONNECT", "CONNECTED", "DISCONNECT", "SEND",
    "SUBSCRIBE", "UNSUBSCRIBE", "BEGIN", "COMMIT", "ABORT", "ACK", "NACK", "ERROR"};

  dp_cmd_t byte_q[$];      // bytes waiting to be driven
  result_t want_q[$];      // results the parser still owes
  result_t step_q[$];      // results of the byte being predicted
  int     fails = 0;
  int     idle_cnt = 0;
  bit     in_taken = 1'b0; // the current byte went across at the last edge
  bit     calm;            // a stretch with no idling on either side

  // Parser state as the predictor sees it.
  logic [2:0]  pr_stage;
  logic [11:0] pr_mask;
  logic [3:0]  pr_idx;
  logic        pr_any, pr_started;
  logic [7:0]  pr_held [WS_DEPTH];
  int          pr_nheld;
  logic [2:0]  pr_err;

  function automatic bit white(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
           c == 8'h0C || c == 8'h0D;
  endfunction

  task automatic clear_parse();
    pr_stage = ST_CMD;
    pr_mask = '1;
    pr_idx = '0;
    pr_any = 1'b0;
    pr_started = 1'b0;
    pr_nheld = 0;
    pr_err = ERR_NONE;
  endtask

  task automatic put(logic [7:0] b, logic v, logic [1:0] k, logic fe, logic cd,
                     logic [3:0] code);
    result_t r;
    r = '{out_byte: b, byte_valid: v, field_kind: k, field_end: fe,
          command_done: cd, command_code: code, error_code: pr_err,
          frame_done: 1'b0, last: 1'b0};
    step_q.push_back(r);
  endtask

  // An error makes one empty result and drops the rest of the frame.
  task automatic flag_error(logic [2:0] code, logic cd);
    pr_err = code;
    pr_stage = ST_DROP;
    pr_nheld = 0;
    put(8'h00, 1'b0, KIND_NONE, 1'b0, cd, 4'd0);
  endtask

  task automatic judge_cmd();
    for (int i = 0; i < NUM_CMDS; i++) begin
      if (pr_mask[i] && cmd_word[i].len() == pr_idx) begin
        put(8'h00, 1'b0, KIND_NONE, 1'b0, 1'b1, 4'(i));
        pr_stage = ST_KEY;
        pr_any = 1'b0;
        pr_started = 1'b0;
        pr_nheld = 0;
        return;
      end
    end
    flag_error(ERR_UNKNOWN, 1'b1);
  endtask

  task automatic cmd_char_in(logic [7:0] c);
    if (c == CH_NUL || c == CH_SPACE) begin
      flag_error(ERR_CMD_FMT, 1'b1);
    end else if (c == CH_LF) begin
      judge_cmd();
    end else if (white(c)) begin
      // Whitespace after the word means any further letter kills every match.
      if (pr_any) pr_started = 1'b1;
    end else begin
      if (pr_started) pr_mask = '0;
      for (int i = 0; i < NUM_CMDS; i++)
        if (pr_idx >= cmd_word[i].len() || cmd_word[i][pr_idx] != c) pr_mask[i] = 1'b0;
      if (pr_idx < 4'd15) pr_idx++;
      pr_any = 1'b1;
    end
  endtask

  // Key and value bytes: leading whitespace is dropped, inner whitespace is held
  // until a later visible byte releases it.
  task automatic text_char_in(logic [7:0] c, logic [1:0] k);
    pr_any = 1'b1;
    if (white(c)) begin
      if (!pr_started) return;
      if (pr_nheld >= WS_DEPTH) begin
        flag_error(ERR_WS_OVF, 1'b0);
        return;
      end
      pr_held[pr_nheld] = c;
      pr_nheld++;
      return;
    end
    for (int i = 0; i < pr_nheld; i++) put(pr_held[i], 1'b1, k, 1'b0, 1'b0, 4'd0);
    pr_nheld = 0;
    put(c, 1'b1, k, 1'b0, 1'b0, 4'd0);
    pr_started = 1'b1;
  endtask

  task automatic close_line();
    if (pr_stage == ST_KEY) begin
      // An empty line opens the payload; a key line with no colon is bad.
      if (pr_any) flag_error(ERR_HEADER, 1'b0);
      else pr_stage = ST_PAY;
      return;
    end
    if (!pr_any) begin
      flag_error(ERR_HEADER, 1'b0);
      return;
    end
    pr_nheld = 0;
    put(8'h00, 1'b0, KIND_VAL, 1'b1, 1'b0, 4'd0);
    pr_stage = ST_KEY;
    pr_any = 1'b0;
    pr_started = 1'b0;
  endtask

  // Works out the results of one accepted byte and queues them.
  task automatic predict_byte(dp_cmd_t d);
    step_q.delete();
    case (pr_stage)
      ST_CMD: cmd_char_in(d.c);
      ST_KEY: begin
        if (d.c == CH_NUL) flag_error(ERR_HEADER, 1'b0);
        else if (d.c == CH_LF) close_line();
        else if (d.c == CH_COLON) begin
          pr_nheld = 0;
          put(8'h00, 1'b0, KIND_KEY, 1'b1, 1'b0, 4'd0);
          pr_stage = ST_VAL;
          pr_any = 1'b0;
          pr_started = 1'b0;
        end else text_char_in(d.c, KIND_KEY);
      end
      ST_VAL: begin
        if (d.c == CH_NUL) flag_error(ERR_HEADER, 1'b0);
        else if (d.c == CH_LF) close_line();
        else text_char_in(d.c, KIND_VAL);
      end
      ST_PAY: put(d.c, 1'b1, KIND_PAY, 1'b0, 1'b0, 4'd0);
      default: pr_stage = ST_DROP;
    endcase
    if (d.fend) begin
      // An open line is closed as if a line feed had come.
      if (pr_stage == ST_CMD) judge_cmd();
      else if (pr_stage == ST_VAL || (pr_stage == ST_KEY && pr_any)) close_line();
      if (step_q.size() == 0) put(8'h00, 1'b0, KIND_NONE, 1'b0, 1'b0, 4'd0);
      step_q[$].error_code = pr_err;
      step_q[$].frame_done = 1'b1;
      clear_parse();
    end
    if (step_q.size() > 0) step_q[$].last = 1'b1;
    foreach (step_q[i]) want_q.push_back(step_q[i]);
  endtask

  // Stimulus helpers.
  task automatic add_byte(logic [7:0] b);
    dp_cmd_t d;
    d.c = b;
    d.fend = 1'b0;
    byte_q.push_back(d);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic end_frame();
    if (byte_q.size() == 0) add_byte(8'h00);
    byte_q[$].fend = 1'b1;
  endtask

  function automatic logic [7:0] any_ws(bit no_space);
    logic [7:0] w [6] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D, 8'h09};
    return w[no_space ? $urandom_range(1, 5) : $urandom_range(0, 5)];
  endfunction

  // A visible header byte: never a colon, a line feed or a NUL.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'((($urandom_range(0, 9) == 0) ? $urandom_range(128, 255)
                                           : $urandom_range(33, 126)));
    while (b == CH_COLON);
    return b;
  endfunction

  task automatic add_field(int n, bit is_val);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        // A run of whitespace; long runs sometimes overflow the holding buffer.
        repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 10 : 3)) add_byte(any_ws(0));
      end
      if (is_val && $urandom_range(0, 9) == 0) add_byte(CH_COLON);
      else add_byte(text_byte());
    end
  endtask

  // A mostly well-formed frame with random content and occasional damage.
  task automatic add_random_frame();
    int k;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(0, 255)));
      end_frame();
      return;
    end
    if ($urandom_range(0, 4) == 0) add_byte(any_ws(1));
    k = $urandom_range(0, NUM_CMDS - 1);
    add_text(cmd_word[k]);
    case ($urandom_range(0, 11))
      0: add_byte(text_byte());
      1: add_byte(CH_SPACE);
      2: add_byte(any_ws(1));
      3: begin
        add_byte(any_ws(1));
        add_byte(text_byte());
      end
      default: ;
    endcase
    if ($urandom_range(0, 19) == 0) begin
      end_frame();
      return;
    end
    add_byte(CH_LF);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 3) == 0) add_byte(any_ws(0));
      add_field($urandom_range(0, 4), 1'b0);
      case ($urandom_range(0, 19))
        0: add_byte(CH_NUL);
        1: ;
        default: add_byte(CH_COLON);
      endcase
      if ($urandom_range(0, 2) == 0) add_byte(any_ws(0));
      add_field($urandom_range(0, 5), 1'b1);
      repeat ($urandom_range(0, 3)) add_byte(any_ws(0));
      if ($urandom_range(0, 14) == 0) begin
        end_frame();
        return;
      end
      add_byte(CH_LF);
    end
    add_byte(CH_LF);
    repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(0, 255)));
    end_frame();
  endtask

  // Driver: bytes change on the falling edge, with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(0, 99) >= 10);
      if (!in_if.valid || in_taken) begin
        if (byte_q.size() > 0 && (calm || $urandom_range(0, 99) >= 10)) begin
          in_if.data <= byte_q.pop_front();
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: both channels are sampled on the rising edge.
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst) begin
      idle_cnt++;
      if (in_if.valid && in_if.ready) begin
        in_taken = 1'b1;
        idle_cnt = 0;
        predict_byte(in_if.data);
      end
      if (out_if.valid && out_if.ready) begin
        idle_cnt = 0;
        if (want_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual %p", $realtime, out_if.data);
        end else if (out_if.data !== want_q[0]) begin
          fails++;
          $display("%0t: result mismatch, expected %p, actual %p", $realtime, want_q[0],
                   out_if.data);
          void'(want_q.pop_front());
        end else begin
          void'(want_q.pop_front());
        end
      end
    end
  end

  // Watchdog: ends a run that stops moving.
  always @(posedge clk) begin
    if (idle_cnt >= 3000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    calm = 1'b0;
    clear_parse();
    for (int i = 0; i < WS_DEPTH; i++) pr_held[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed frames: a clean frame with extreme payload bytes, a space and a
    // NUL on the command line, an unknown and an empty command, a header with
    // no colon, a colon ending the line, a NUL among the headers, a value of
    // only whitespace, a whitespace overflow, and a frame ending mid-header.
    add_text("SEND\nk: v\n\n");
    add_byte(8'h00);
    add_byte(8'hFF);
    end_frame();
    add_text("SE ND\n");
    end_frame();
    add_byte(CH_NUL);
    end_frame();
    add_text("FOO\n");
    end_frame();
    add_byte(CH_LF);
    end_frame();
    add_text("ACK\nnocolon\n");
    end_frame();
    add_text("NACK\nk:\n");
    end_frame();
    add_text("ERROR\n");
    add_byte(CH_NUL);
    end_frame();
    add_text("BEGIN\n:\t \n\n");
    end_frame();
    add_text("ABORT\nk:a");
    repeat (9) add_byte(8'h20);
    add_text("b\n");
    end_frame();
    add_text("COMMIT\t\r\nk:v");
    end_frame();

    // Random frames; the middle part runs without idling.
    while (byte_q.size() < 400) add_random_frame();
    wait (byte_q.size() < 250);
    calm = 1'b1;
    wait (byte_q.size() < 120);
    calm = 1'b0;
    wait (byte_q.size() == 0 && !in_if.valid);
    wait (want_q.size() == 0);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
